// File: rtl/core/dpd_pkg.sv
// ----------------------------------------------------------------------------
// dpd_pkg
// Shared widths, character codes, result kinds and the command format
// passed from the deframer front to its back end.
// ----------------------------------------------------------------------------
package dpd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 11;
  localparam int unsigned KindW = 3;

  localparam int unsigned PayloadLimitDefault = 2047;
  localparam int unsigned QueueDepthDefault   = 4;

  localparam logic [ByteW-1:0] CharStart = 8'h24; // '$'
  localparam logic [ByteW-1:0] CharEnd   = 8'h23; // '#'
  localparam logic [ByteW-1:0] CharColon = 8'h3A; // ':'
  localparam logic [ByteW-1:0] CharAck   = 8'h2B; // '+'
  localparam logic [ByteW-1:0] CharNak   = 8'h2D; // '-'

  typedef enum logic [KindW-1:0] {
    KIND_DATA    = 3'd0,
    KIND_XMIT    = 3'd1,
    KIND_ACCEPT  = 3'd2,
    KIND_REJECT  = 3'd3,
    KIND_ABANDON = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    CMD_DATA       = 3'd0,
    CMD_DATA_LIMIT = 3'd1,
    CMD_ABANDON    = 3'd2,
    CMD_ACCEPT     = 3'd3,
    CMD_ACCEPT_SEQ = 3'd4,
    CMD_REJECT     = 3'd5
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e          op;
    logic [ByteW-1:0] data;
    logic [PosW-1:0]  pos;
    logic [PosW-1:0]  len;
    logic [ByteW-1:0] head0;
    logic [ByteW-1:0] head1;
  } cmd_t;

  // hex digit value, all-ones for anything that is not a hex digit
  function automatic logic [ByteW-1:0] hex_value(logic [ByteW-1:0] c);
    logic [ByteW-1:0] v;
    if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end else begin
      v = 8'hFF;
    end
    return v;
  endfunction

endpackage

// File: rtl/core/dpd_in_if.sv
// ----------------------------------------------------------------------------
// dpd_in_if
// Valid/ready channel carrying one received byte per beat.
// ----------------------------------------------------------------------------
interface dpd_in_if;
  logic                      valid;
  logic                      ready;
  logic [dpd_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: rtl/core/dpd_out_if.sv
// ----------------------------------------------------------------------------
// dpd_out_if
// Valid/ready channel carrying one deframer result per beat.
// ----------------------------------------------------------------------------
interface dpd_out_if;
  logic                      valid;
  logic                      ready;
  logic [dpd_pkg::KindW-1:0] kind;
  logic [dpd_pkg::ByteW-1:0] byte_value;
  logic [dpd_pkg::PosW-1:0]  position;
  logic                      seq_present;
  logic                      last;

  modport source (output valid, output kind, output byte_value, output position,
                  output seq_present, output last, input ready);
  modport sink   (input valid, input kind, input byte_value, input position,
                  input seq_present, input last, output ready);
endinterface

// File: rtl/core/dpd_front.sv
// ----------------------------------------------------------------------------
// dpd_front
// Framing state machine: hunts for the start mark, tracks payload length and
// checksum, and turns each received byte into at most one result command.
// ----------------------------------------------------------------------------
module dpd_front #(
  parameter int unsigned PayloadLimit = dpd_pkg::PayloadLimitDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  dpd_in_if.sink         rx_i,
  output logic           cmd_valid_o,
  output dpd_pkg::cmd_t  cmd_o,
  input  logic           cmd_ready_i
);
  import dpd_pkg::*;

  localparam int unsigned LimW = $clog2(PayloadLimit + 1);
  localparam int unsigned CntW = (LimW > PosW) ? LimW : PosW;

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_DATA = 4'b0010,
    PH_HIGH = 4'b0100,
    PH_LOW  = 4'b1000
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [ByteW-1:0]  run_sum_q, run_sum_d;
  logic [ByteW-1:0]  sent_sum_q, sent_sum_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [ByteW-1:0]  head_q [3];

  logic              beat;
  logic [ByteW-1:0]  c;
  logic [ByteW-1:0]  hex;
  logic [ByteW-1:0]  check;
  logic [CntW-1:0]   count_inc;
  logic              at_limit;
  logic              seq;
  logic              head_we;

  assign rx_i.ready = cmd_ready_i;
  assign beat       = rx_i.valid && rx_i.ready;
  assign c          = rx_i.rx_byte;
  assign hex        = hex_value(c);
  assign check      = sent_sum_q + hex;
  assign count_inc  = count_q + CntW'(1);
  assign at_limit   = (count_q == CntW'(PayloadLimit - 1));
  assign seq        = (count_q >= CntW'(3)) && (head_q[2] == CharColon);

  always_comb begin
    phase_d     = phase_q;
    run_sum_d   = run_sum_q;
    sent_sum_d  = sent_sum_q;
    count_d     = count_q;
    head_we     = 1'b0;
    cmd_valid_o = 1'b0;
    cmd_o.op    = CMD_DATA;
    cmd_o.data  = c;
    cmd_o.pos   = count_q[PosW-1:0];
    cmd_o.len   = count_q[PosW-1:0];
    cmd_o.head0 = head_q[0];
    cmd_o.head1 = head_q[1];
    if (beat) begin
      case (phase_q)
        PH_HUNT: begin
          if (c == CharStart) begin
            run_sum_d  = '0;
            sent_sum_d = '0;
            count_d    = '0;
            phase_d    = PH_DATA;
          end
        end
        PH_DATA: begin
          if (c == CharStart) begin
            // restart: report what was reached, then begin a fresh packet
            cmd_valid_o = 1'b1;
            cmd_o.op    = CMD_ABANDON;
            run_sum_d   = '0;
            sent_sum_d  = '0;
            count_d     = '0;
          end else if (c == CharEnd) begin
            phase_d = PH_HIGH;
          end else begin
            run_sum_d   = run_sum_q + c;
            head_we     = (count_q < CntW'(3));
            cmd_valid_o = 1'b1;
            cmd_o.len   = count_inc[PosW-1:0];
            count_d     = count_inc;
            if (at_limit) begin
              cmd_o.op = CMD_DATA_LIMIT;
              phase_d  = PH_HUNT;
            end else begin
              cmd_o.op = CMD_DATA;
            end
          end
        end
        PH_HIGH: begin
          sent_sum_d = {hex[3:0], 4'h0};
          phase_d    = PH_LOW;
        end
        PH_LOW: begin
          sent_sum_d  = check;
          cmd_valid_o = 1'b1;
          if (check == run_sum_q) begin
            cmd_o.op = seq ? CMD_ACCEPT_SEQ : CMD_ACCEPT;
          end else begin
            cmd_o.op = CMD_REJECT;
          end
          phase_d = PH_HUNT;
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      run_sum_q  <= '0;
      sent_sum_q <= '0;
      count_q    <= '0;
    end else begin
      phase_q    <= phase_d;
      run_sum_q  <= run_sum_d;
      sent_sum_q <= sent_sum_d;
      count_q    <= count_d;
    end
  end

  // first three payload bytes, only read once all three are written
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_q[count_q[1:0]] <= c;
    end
  end

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_o |-> cmd_ready_i)
    else $error("command pushed into a full queue");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> count_q < CntW'(PayloadLimit))
    else $error("payload count reached the limit while still in payload");

endmodule

// File: rtl/core/dpd_queue.sv
// ----------------------------------------------------------------------------
// dpd_queue
// Small register FIFO of result commands between front and back end.
// ----------------------------------------------------------------------------
module dpd_queue #(
  parameter int unsigned Depth = dpd_pkg::QueueDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  dpd_pkg::cmd_t  push_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output dpd_pkg::cmd_t  pop_o,
  input  logic           pop_ready_i
);
  import dpd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic            push;
  logic            pop;

  assign push_ready_o = (fill_q != CntW'(Depth));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_o        = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      fill_d = fill_q + CntW'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i;
    end
  end

endmodule

// File: rtl/core/dpd_back.sv
// ----------------------------------------------------------------------------
// dpd_back
// Expands the command at the queue head into one to four result beats and
// drives them through a registered output stage.
// ----------------------------------------------------------------------------
module dpd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  dpd_pkg::cmd_t  cmd_i,
  output logic           cmd_ready_o,
  dpd_out_if.source      res_o
);
  import dpd_pkg::*;

  logic [1:0]       idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  kind_e            kind_q;
  logic [ByteW-1:0] byte_q;
  logic [PosW-1:0]  pos_q;
  logic             seq_q;
  logic             last_q;

  kind_e            b_kind;
  logic [ByteW-1:0] b_byte;
  logic [PosW-1:0]  b_pos;
  logic             b_seq;
  logic             b_last;
  logic             load;
  logic             advance;

  // beat number idx_q of the current command
  always_comb begin
    b_kind = KIND_XMIT;
    b_byte = '0;
    b_pos  = '0;
    b_seq  = 1'b0;
    b_last = 1'b0;
    case (cmd_i.op)
      CMD_DATA: begin
        b_kind = KIND_DATA;
        b_byte = cmd_i.data;
        b_pos  = cmd_i.pos;
        b_last = 1'b1;
      end
      CMD_DATA_LIMIT: begin
        if (idx_q == 2'd0) begin
          b_kind = KIND_DATA;
          b_byte = cmd_i.data;
          b_pos  = cmd_i.pos;
        end else begin
          b_kind = KIND_ABANDON;
          b_pos  = cmd_i.len;
          b_last = 1'b1;
        end
      end
      CMD_ABANDON: begin
        b_kind = KIND_ABANDON;
        b_pos  = cmd_i.len;
        b_last = 1'b1;
      end
      CMD_ACCEPT: begin
        if (idx_q == 2'd0) begin
          b_byte = CharAck;
        end else begin
          b_kind = KIND_ACCEPT;
          b_pos  = cmd_i.len;
          b_last = 1'b1;
        end
      end
      CMD_ACCEPT_SEQ: begin
        case (idx_q)
          2'd0: b_byte = CharAck;
          2'd1: b_byte = cmd_i.head0;
          2'd2: b_byte = cmd_i.head1;
          default: begin
            b_kind = KIND_ACCEPT;
            b_pos  = cmd_i.len;
            b_seq  = 1'b1;
            b_last = 1'b1;
          end
        endcase
      end
      CMD_REJECT: begin
        if (idx_q == 2'd0) begin
          b_byte = CharNak;
        end else begin
          b_kind = KIND_REJECT;
          b_pos  = cmd_i.len;
          b_last = 1'b1;
        end
      end
      default: begin
        b_last = 1'b1;
      end
    endcase
  end

  assign load        = !out_valid_q || res_o.ready;
  assign advance     = load && cmd_valid_i;
  assign cmd_ready_o = advance && b_last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = cmd_valid_i;
    end
    if (advance) begin
      idx_d = b_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      kind_q <= b_kind;
      byte_q <= b_byte;
      pos_q  <= b_pos;
      seq_q  <= b_seq;
      last_q <= b_last;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.kind        = kind_q;
  assign res_o.byte_value  = byte_q;
  assign res_o.position    = pos_q;
  assign res_o.seq_present = seq_q;
  assign res_o.last        = last_q;

  a_partial_cmd_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 2'd0 |-> cmd_valid_i)
    else $error("command left the queue before all its beats were sent");

  a_verdict_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (kind_q == KIND_ACCEPT || kind_q == KIND_REJECT ||
                    kind_q == KIND_ABANDON) |-> last_q)
    else $error("verdict beat not marked last");

  a_xmit_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == KIND_XMIT |-> !last_q && pos_q == '0)
    else $error("transmit beat ends a command or carries a position");

endmodule

// File: rtl/core/debug_packet_deframer.sv
// ----------------------------------------------------------------------------
// debug_packet_deframer
// Deframes '$'-started, '#'-checksummed debug link packets into payload,
// transmit and verdict result beats.
// ----------------------------------------------------------------------------
// path: byte -> command queue -> output register, which holds each result beat
// throughput: one byte per cycle while the command queue has room; a byte causes
//   at most four result beats, and the command queue absorbs bursts
// the output register, one beat per cycle while res_o.ready is high, sets the sustained result rate
// reset: asynchronous, clears queue and output stage and starts hunting for '$'
module debug_packet_deframer #(
  parameter int unsigned PayloadLimit = dpd_pkg::PayloadLimitDefault,
  parameter int unsigned QueueDepth   = dpd_pkg::QueueDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dpd_in_if.sink    rx_i,
  dpd_out_if.source res_o
);
  import dpd_pkg::*;

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  dpd_front #(
    .PayloadLimit (PayloadLimit)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_i),
    .cmd_valid_o (push_valid),
    .cmd_o       (push_cmd),
    .cmd_ready_i (push_ready)
  );

  dpd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_i       (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_o        (pop_cmd),
    .pop_ready_i  (pop_ready)
  );

  dpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_i       (pop_cmd),
    .cmd_ready_o (pop_ready),
    .res_o       (res_o)
  );

endmodule
